/* rtl/core/dbpq_pkg.sv */
// Shared types, constants and helpers for the deduplicating priority queue.
`timescale 1ns / 1ps

package dbpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int HASH_W      = 64;
    localparam int FREQ_W      = 32;
    localparam int DROP_W      = 32;
    localparam int OCC_W       = 7;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 144;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // request codes; the high bit alone means shutdown
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;

    localparam logic [2:0] ST_ENQ      = 3'd0;
    localparam logic [2:0] ST_EVICT    = 3'd1;
    localparam logic [2:0] ST_SHUT     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_DEQ      = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;
    localparam logic [2:0] ST_SHUT_ACK = 3'd7;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              warmup;
        logic [FREQ_W-1:0] freq;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic     cmp;
        t_cell_op op;
        t_entry   item;
    } t_cell_ctl;

    // true when a outranks b: warmup first, then higher frequency
    function automatic logic higher(t_entry a, t_entry b);
        return (a.warmup && !b.warmup) || ((a.warmup == b.warmup) && (a.freq > b.freq));
    endfunction

endpackage

/* rtl/core/dedup_bounded_priority_queue.sv */
// Top level of the deduplicating bounded priority queue built as a row of cells.
`timescale 1ns / 1ps
// A request passes the compare state, then the execute state; the result is registered.
// The next item is taken in the execute cycle of the current one, so a new item is not
//   accepted while the current one is still in compare.
// Execute stalls while the output register holds an untaken result.
// Reset (synchronous, active low) empties the queue, clears drop count and shutdown,
//   sets capacity to 64; entry storage is not cleared.

module dedup_bounded_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: capacity register
    input  logic                            i_cfg_we,
    input  logic [dbpq_pkg::CAP_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: new_hash[63:0], new_warmup[64], new_frequency[96:65], zero pad
    input  logic [dbpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                      s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: out_hash[63:0], out_warmup[64], out_frequency[96:65], occupancy[103:97],
    //        drop_total[135:104], is_shut[136], zero pad
    output logic [dbpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]                      m_axis_tuser
);

    localparam int QD = dbpq_pkg::QUEUE_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXE
    } t_state;

    t_state r_state;

    // latched request
    logic [1:0]       r_req;
    dbpq_pkg::t_entry r_item;

    // queue state
    logic [dbpq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [dbpq_pkg::DROP_W-1:0] r_drop, n_drop;
    logic                        r_shut, n_shut;
    logic [dbpq_pkg::CAP_W-1:0]  r_capacity;

    // compare results
    logic r_dup;
    logic r_beats_tail;

    // output register
    logic                         r_ovalid;
    logic [2:0]                   r_ostatus, n_ostatus;
    dbpq_pkg::t_entry             r_oentry, n_oentry;
    logic [dbpq_pkg::CNT_W-1:0]   r_ocount;
    logic [dbpq_pkg::DROP_W-1:0]  r_odrop;
    logic                         r_oshut;

    // cell row
    dbpq_pkg::t_entry    c_entry [QD];
    logic [QD-1:0]       c_keep;
    logic [QD-1:0]       c_match;
    logic [QD-1:0]       c_beats;
    logic [QD-1:0]       c_live;
    dbpq_pkg::t_cell_ctl c_ctl;
    dbpq_pkg::t_cell_op  n_op;

    logic                       out_free;
    logic                       exe_go;
    logic                       in_acc;
    logic [dbpq_pkg::IDX_W-1:0] tail_idx;
    logic [dbpq_pkg::CMP_W-1:0] cap_ext, cap_eff, count_ext;
    logic                       full;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign exe_go        = (r_state == S_EXE) && out_free;
    assign s_axis_tready = (r_state == S_IDLE) || exe_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign tail_idx  = dbpq_pkg::IDX_W'(r_count - dbpq_pkg::CNT_W'(1));

    // capacity clamped to 1..depth
    assign cap_ext   = dbpq_pkg::CMP_W'(r_capacity);
    assign count_ext = dbpq_pkg::CMP_W'(r_count);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = dbpq_pkg::CMP_W'(1);
        end else if (cap_ext > dbpq_pkg::CMP_W'(QD)) begin
            cap_eff = dbpq_pkg::CMP_W'(QD);
        end else begin
            cap_eff = cap_ext;
        end
    end
    assign full = (count_ext >= cap_eff) && (r_count != '0);

    // execute decision
    always_comb begin
        n_op      = dbpq_pkg::OP_HOLD;
        n_count   = r_count;
        n_drop    = r_drop;
        n_shut    = r_shut;
        n_ostatus = dbpq_pkg::ST_SHUT_ACK;
        n_oentry  = '0;
        if (r_req[1]) begin
            n_shut    = 1'b1;
            n_ostatus = dbpq_pkg::ST_SHUT_ACK;
        end else if (r_req == dbpq_pkg::REQ_DEQ) begin
            if (r_count == '0) begin
                n_ostatus = dbpq_pkg::ST_EMPTY;
            end else begin
                n_op      = dbpq_pkg::OP_SHIFT;
                n_oentry  = c_entry[0];
                n_count   = r_count - dbpq_pkg::CNT_W'(1);
                n_ostatus = dbpq_pkg::ST_DEQ;
            end
        end else begin
            if (r_shut) begin
                n_ostatus = dbpq_pkg::ST_SHUT;
            end else if (r_dup) begin
                n_ostatus = dbpq_pkg::ST_DUP;
            end else if (full) begin
                if (r_drop != '1) begin
                    n_drop = r_drop + dbpq_pkg::DROP_W'(1);
                end
                if (r_beats_tail) begin
                    // tail leaves, new item goes in: count unchanged
                    n_op      = dbpq_pkg::OP_INSERT;
                    n_ostatus = dbpq_pkg::ST_EVICT;
                end else begin
                    n_ostatus = dbpq_pkg::ST_FULL;
                end
            end else begin
                n_op      = dbpq_pkg::OP_INSERT;
                n_count   = r_count + dbpq_pkg::CNT_W'(1);
                n_ostatus = dbpq_pkg::ST_ENQ;
            end
        end
    end

    assign c_ctl.cmp  = (r_state == S_CMP);
    assign c_ctl.op   = exe_go ? n_op : dbpq_pkg::OP_HOLD;
    assign c_ctl.item = r_item;

    genvar gi;
    generate
        for (gi = 0; gi < QD; gi++) begin : g_cell
            logic             keep_prev;
            dbpq_pkg::t_entry left_entry;
            dbpq_pkg::t_entry right_entry;

            assign c_live[gi] = (r_count > dbpq_pkg::CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign keep_prev  = 1'b0;
                assign left_entry = r_item;
            end else begin : g_mid
                assign keep_prev  = c_keep[gi-1];
                assign left_entry = c_entry[gi-1];
            end

            if (gi == QD - 1) begin : g_last
                assign right_entry = c_entry[gi];
            end else begin : g_inner
                assign right_entry = c_entry[gi+1];
            end

            dbpq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (c_ctl),
                .i_live      (c_live[gi]),
                .i_keep_prev (keep_prev),
                .i_left      (left_entry),
                .i_right     (right_entry),
                .o_entry     (c_entry[gi]),
                .o_keep      (c_keep[gi]),
                .o_match     (c_match[gi]),
                .o_beats     (c_beats[gi])
            );
        end
    endgenerate

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_drop       <= '0;
            r_shut       <= 1'b0;
            r_capacity   <= dbpq_pkg::CAP_RESET;
            r_dup        <= 1'b0;
            r_beats_tail <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (r_state == S_CMP) begin
                r_dup        <= |c_match;
                r_beats_tail <= (r_count != '0) && c_beats[tail_idx];
            end
            if (exe_go) begin
                r_count  <= n_count;
                r_drop   <= n_drop;
                r_shut   <= n_shut;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    if (exe_go) begin
                        r_state <= in_acc ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req         <= s_axis_tuser;
            r_item.hash   <= s_axis_tdata[63:0];
            r_item.warmup <= s_axis_tdata[64];
            r_item.freq   <= s_axis_tdata[96:65];
        end
        if (exe_go) begin
            r_ostatus <= n_ostatus;
            r_oentry  <= n_oentry;
            r_ocount  <= n_count;
            r_odrop   <= n_drop;
            r_oshut   <= n_shut;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {7'd0, r_oshut, r_odrop, r_ocount[dbpq_pkg::OCC_W-1:0],
                            r_oentry.freq, r_oentry.warmup, r_oentry.hash};

`ifndef SYNTH
    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dbpq_pkg::CNT_W'(QD))
        else $error("queue count above depth");

    // count moves only on an execute step
    a_count_exe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exe_go |=> $stable(r_count))
        else $error("queue count changed outside execute");

    // count moves by at most one per step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exe_go |-> (n_count == r_count) || (n_count == r_count + dbpq_pkg::CNT_W'(1))
                   || (n_count + dbpq_pkg::CNT_W'(1) == r_count))
        else $error("queue count jumped");

    // an accepted item is always compared next
    a_acc_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CMP))
        else $error("accepted item skipped compare");

    // drop counter never goes down
    a_drop_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exe_go |-> (n_drop >= r_drop))
        else $error("drop counter decreased");
`endif

endmodule

/* rtl/core/dbpq_cell.sv */
// One slot of the sorted queue: holds an entry, compares it, shifts with neighbors.
`timescale 1ns / 1ps

module dbpq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dbpq_pkg::t_cell_ctl i_ctl,
    input  logic               i_live,
    input  logic               i_keep_prev,
    input  dbpq_pkg::t_entry   i_left,
    input  dbpq_pkg::t_entry   i_right,
    output dbpq_pkg::t_entry   o_entry,
    output logic               o_keep,
    output logic               o_match,
    output logic               o_beats
);

    dbpq_pkg::t_entry r_entry;
    logic             r_ahead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahead <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_ahead <= i_live && dbpq_pkg::higher(r_entry, i_ctl.item);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            dbpq_pkg::OP_INSERT: begin
                // cells ahead of the new item keep; the first one behind takes it
                if (!r_ahead) begin
                    r_entry <= i_keep_prev ? i_ctl.item : i_left;
                end
            end
            dbpq_pkg::OP_SHIFT: begin
                r_entry <= i_right;
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_keep  = r_ahead;
    assign o_match = i_live && (r_entry.hash == i_ctl.item.hash);
    assign o_beats = dbpq_pkg::higher(i_ctl.item, r_entry);

endmodule

/* bench/dedup_bounded_priority_queue_test.sv */
// Self-checking testbench for the deduplicating bounded priority queue.
`timescale 1ns / 1ps

module dedup_bounded_priority_queue_test;
    import dbpq_pkg::*;

    // shutdown request codes; the block decodes shutdown from the high bit alone
    localparam logic [1:0] REQ_SHUT     = 2'd2;
    localparam logic [1:0] REQ_SHUT_ALT = 2'd3;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 6;     // covers the compare and execute steps with margin on top
    localparam int IN_PAD        = IN_DATA_W - HASH_W - 1 - FREQ_W;

    // one result as the block should report it
    typedef struct packed {
        logic [2:0]        status;
        logic [HASH_W-1:0] hash;
        logic              warmup;
        logic [FREQ_W-1:0] freq;
        logic [OCC_W-1:0]  occ;
        logic [DROP_W-1:0] drops;
        logic              shut;
    } t_outcome;

    // Mirrors the queue contents, drop count, shutdown flag and capacity, and keeps
    // the results still owed by the block in arrival order.
    class pq_tracker;
        t_entry            slots[$];      // head at index 0
        logic [DROP_W-1:0] drops;
        logic              shut;
        logic [CAP_W-1:0]  cap;
        t_outcome          awaited[$];
        int                failures;
        int                checked;
        int                status_seen[8];

        function new();
            drops    = '0;
            shut     = 1'b0;
            cap      = CAP_RESET;
            failures = 0;
            checked  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // warmup beats non-warmup; otherwise strictly larger frequency wins
        function bit outranks(t_entry a, t_entry b);
            if (a.warmup != b.warmup) return a.warmup;
            return a.freq > b.freq;
        endfunction

        function void bump_drops();
            if (drops != '1) drops++;
        endfunction

        function logic [2:0] enqueue(t_entry e);
            int         limit;
            int         pos;
            logic [2:0] st;
            if (shut) return ST_SHUT;
            foreach (slots[i]) begin
                if (slots[i].hash == e.hash) return ST_DUP;
            end
            // zero acts as one, anything past the depth is clamped
            limit = (cap == 0) ? 1 : (cap > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cap);
            st = ST_ENQ;
            // over capacity (also after a lowered capacity): at most one tail leaves
            if (slots.size() >= limit) begin
                if (!outranks(e, slots[$])) begin
                    bump_drops();
                    return ST_FULL;
                end
                slots.delete(slots.size() - 1);
                bump_drops();
                st = ST_EVICT;
            end
            // new item lands ahead of equal priority
            pos = 0;
            while (pos < slots.size() && outranks(slots[pos], e)) pos++;
            slots.insert(pos, e);
            return st;
        endfunction

        function void take_request(logic [1:0] req, t_entry e);
            t_outcome r;
            t_entry   head;
            r = '0;
            if (req == REQ_ENQ) begin
                r.status = enqueue(e);
            end else if (req == REQ_DEQ) begin
                if (slots.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head = slots[0];
                    slots.delete(0);
                    r.status = ST_DEQ;
                    r.hash   = head.hash;
                    r.warmup = head.warmup;
                    r.freq   = head.freq;
                end
            end else begin
                shut     = 1'b1;
                r.status = ST_SHUT_ACK;
            end
            r.occ   = OCC_W'(slots.size());
            r.drops = drops;
            r.shut  = shut;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            failures++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
        endtask

        task take_result(logic [2:0] status, logic [OUT_DATA_W-1:0] data);
            t_outcome want;
            checked++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            status_seen[want.status]++;
            check_field("status", status, want.status);
            check_field("hash", data[63:0], want.hash);
            check_field("warmup", data[64], want.warmup);
            check_field("frequency", data[96:65], want.freq);
            check_field("occupancy", data[103:97], want.occ);
            check_field("drop_total", data[135:104], want.drops);
            check_field("is_shut", data[136], want.shut);
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = REQ_ENQ;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;

    pq_tracker         tracker;
    logic [HASH_W-1:0] used_hashes[$];   // recent hashes, to revisit after they leave
    int                sent       = 0;
    int                stall_left = 0;
    int                idle_run   = 0;
    bit                calm       = 1'b0;  // no gaps or stalls while set

    dedup_bounded_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int random_pause();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_entry make_entry(logic [HASH_W-1:0] h, logic w, logic [FREQ_W-1:0] f);
        t_entry e;
        e.hash   = h;
        e.warmup = w;
        e.freq   = f;
        return e;
    endfunction

    // Random item: hashes sometimes repeat a queued one (duplicate) or an old one,
    // frequencies often collide so ties and equal-priority drops show up.
    function automatic t_entry random_entry();
        t_entry e;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 20 && tracker.slots.size() > 0)
            e.hash = tracker.slots[$urandom_range(0, tracker.slots.size() - 1)].hash;
        else if (r < 30 && used_hashes.size() > 0)
            e.hash = used_hashes[$urandom_range(0, used_hashes.size() - 1)];
        else
            e.hash = {$urandom, $urandom};
        e.warmup = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 40)
            e.freq = $urandom_range(0, 7);
        else if (r < 50)
            e.freq = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : 32'h0;
        else
            e.freq = $urandom;
        return e;
    endfunction

    // present one item and hold it until taken; tvalid is left high
    task automatic send_item(logic [1:0] req, t_entry e);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{IN_PAD{1'b0}}, e.freq, e.warmup, e.hash};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_request(req, e);
        sent++;
        if (req == REQ_ENQ) begin
            used_hashes.push_back(e.hash);
            if (used_hashes.size() > 64) used_hashes.delete(0);
        end
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed result is back, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.cap = v;
    endtask

    // enq_pct enqueues, shut_pct shutdowns (either code), the rest dequeues
    task automatic run_phase(int n, int enq_pct, int shut_pct);
        logic [1:0] req;
        int         r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct)
                req = REQ_ENQ;
            else if (r < enq_pct + shut_pct)
                req = $urandom_range(0, 1) ? REQ_SHUT_ALT : REQ_SHUT;
            else
                req = REQ_DEQ;
            send_item(req, random_entry());
            if ($urandom_range(0, 59) == 0)
                drain();
            else
                hold_off(random_pause());
        end
    endtask

    task automatic directed();
        send_item(REQ_DEQ, make_entry('1, 1'b1, '1));               // pop from empty
        send_item(REQ_ENQ, make_entry('0, 1'b0, '0));
        send_item(REQ_ENQ, make_entry('1, 1'b1, '1));
        send_item(REQ_ENQ, make_entry(64'h5555_5555_5555_5555, 1'b0, 32'd7));
        send_item(REQ_ENQ, make_entry(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'd0));
        send_item(REQ_ENQ, make_entry(64'h0123_4567_89AB_CDEF, 1'b0, 32'd7)); // tie: goes first
        send_item(REQ_ENQ, make_entry('0, 1'b1, '1));               // duplicate hash
        repeat (6) send_item(REQ_DEQ, make_entry({$urandom, $urandom}, 1'b0, $urandom));
        write_capacity(7'd0);                                       // behaves as one
        send_item(REQ_ENQ, make_entry(64'h11, 1'b0, 32'd5));
        send_item(REQ_ENQ, make_entry(64'h22, 1'b0, 32'd5));       // equal priority: dropped
        send_item(REQ_ENQ, make_entry(64'h33, 1'b0, 32'd6));       // higher: evicts tail
        send_item(REQ_ENQ, make_entry(64'h44, 1'b1, 32'd0));       // warmup outranks
        send_item(REQ_DEQ, make_entry('0, 1'b0, '0));
        send_item(REQ_DEQ, make_entry('0, 1'b0, '0));
    endtask

    // results side: check what is taken, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.take_result(m_axis_tuser, m_axis_tdata);
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = random_pause();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed();

        // fill at full depth so evictions and full drops appear
        write_capacity(CAP_RESET);
        run_phase(400, 70, 0);
        // lowered under the current occupancy
        write_capacity(7'd8);
        run_phase(150, 60, 0);
        calm = 1'b1;
        write_capacity(7'd1);
        run_phase(150, 55, 0);
        calm = 1'b0;
        // past the depth: clamps to 64
        write_capacity(7'd127);
        run_phase(300, 65, 0);
        write_capacity(7'd0);
        run_phase(100, 50, 0);
        repeat (2) begin
            write_capacity(CAP_W'($urandom_range(2, 63)));
            run_phase(200, 55, 0);
        end
        write_capacity(CAP_RESET);
        run_phase(150, 30, 0);

        // shutdown: refused enqueues, repeated acks, dequeues still drain
        send_item(REQ_SHUT_ALT, random_entry());
        send_item(REQ_ENQ, random_entry());
        send_item(REQ_SHUT, random_entry());
        run_phase(150, 35, 10);

        drain();

        $display("Ran %0d requests, checked %0d results across capacities 0, 1, 8, 64, 127",
                 sent, tracker.checked);
        $display("  and two random ones; statuses enq/evict/refused/dup/full/deq/empty/ack:"
                 , " %0d %0d %0d %0d %0d %0d %0d %0d",
                 tracker.status_seen[ST_ENQ], tracker.status_seen[ST_EVICT],
                 tracker.status_seen[ST_SHUT], tracker.status_seen[ST_DUP],
                 tracker.status_seen[ST_FULL], tracker.status_seen[ST_DEQ],
                 tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_SHUT_ACK]);
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
